// ===== rtl/core/ioreseq_pkg.sv =====
// Shared types and constants for the in-order resequencer.
// No dependencies; imported by the top level and the arithmetic unit.
package ioreseq_pkg;

  localparam int unsigned SEQ_W    = 16;
  localparam int unsigned PAY_W    = 32;
  localparam int unsigned STATUS_W = 2;
  // Stream data: sequence in the low 16 bits, payload above it.
  localparam int unsigned TDATA_W  = SEQ_W + PAY_W;

  typedef logic [SEQ_W-1:0] seq_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DELIVER = 2'd0,
    ST_STORED  = 2'd1,
    ST_DUP     = 2'd2,
    ST_DROP    = 2'd3
  } status_e;

  typedef enum logic {
    ALU_DIST = 1'b0,
    ALU_INC  = 1'b1
  } alu_op_e;

endpackage

// ===== rtl/core/in_order_resequencer.sv =====
// In-order resequencer: sequence-number reorder buffer, top level.
// A request is taken in IDLE and classified in EVAL, which registers a stored, duplicate or
// dropped result; an in-order item is delivered from ADV, and each further buffered item of the
// run is read in RD and then delivered from ADV. No new request is taken until the block is back
// in IDLE. Output back-pressure stalls EVAL and ADV; the shared unit and memory read set the pace.
// Reset: expected counter 0, all slots empty; the payload memory is not cleared.
module in_order_resequencer #(
  parameter int unsigned WINDOW       = 64,
  parameter int unsigned PAYLOAD_BITS = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Configuration: start sequence number, loaded into the expected counter.
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  ioreseq_pkg::seq_t            cfg_data_i,
  // Input stream; tdata from bit 0: sequence_req[15:0], payload[31:0].
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  input  logic [ioreseq_pkg::TDATA_W-1:0] s_axis_tdata_i,
  // Result stream; tdata from bit 0: out_sequence[15:0], out_payload[31:0].
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  output logic [ioreseq_pkg::TDATA_W-1:0] m_axis_tdata_o,
  // tuser: status[1:0].
  output logic [ioreseq_pkg::STATUS_W-1:0] m_axis_tuser_o,
  output logic                         m_axis_tlast_o
);
  import ioreseq_pkg::*;

  localparam int unsigned IW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  // Payload bits actually kept: the stream field carries at most PAY_W.
  localparam int unsigned SW = (PAYLOAD_BITS < PAY_W) ? PAYLOAD_BITS : PAY_W;

  // The sequencer walks each request through the shared arithmetic unit.
  // EVAL classifies the request, ADV delivers one item and advances the
  // expected counter, RD waits for the payload of the next buffered item.
  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_ADV,
    S_RD
  } state_e;

  state_e             state_q, state_d;
  seq_t               exp_q, exp_d;
  logic [IW-1:0]      head_q, head_d;
  logic [WINDOW-1:0]  valid_q, valid_d;
  seq_t               seq_q, seq_d;
  logic [SW-1:0]      pay_q, pay_d;

  logic               out_valid_q, out_valid_d;
  status_e            out_status_q, out_status_d;
  seq_t               out_seq_q, out_seq_d;
  logic [SW-1:0]      out_pay_q, out_pay_d;
  logic               out_last_q, out_last_d;

  alu_op_e            alu_op;
  seq_t               alu_diff;
  logic               alu_in_win;
  logic [IW-1:0]      alu_idx;

  logic               mem_we;
  logic [SW-1:0]      mem_rdata;

  logic               out_free;
  logic               in_req;
  logic               cfg_req;

  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign cfg_ready_o     = (state_q == S_IDLE);
  // A configuration write takes precedence over a new item.
  assign s_axis_tready_o = (state_q == S_IDLE) && !cfg_valid_i;
  assign cfg_req         = cfg_valid_i && cfg_ready_o;
  assign in_req          = s_axis_tvalid_i && s_axis_tready_o;

  // In EVAL the unit measures the distance from the expected number and
  // finds the slot; in ADV it increments the counter and steps the head.
  assign alu_op = (state_q == S_ADV) ? ALU_INC : ALU_DIST;

  ioreseq_alu #(
    .WINDOW (WINDOW),
    .IW     (IW)
  ) u_alu (
    .op_i     (alu_op),
    .a_i      ((state_q == S_ADV) ? exp_q : seq_q),
    .b_i      (exp_q),
    .base_i   (head_q),
    .diff_o   (alu_diff),
    .in_win_o (alu_in_win),
    .idx_o    (alu_idx)
  );

  // The store is written in EVAL and read at the next head slot in ADV.
  assign mem_we = (state_q == S_EVAL) && out_free && alu_in_win &&
                  (alu_diff != '0) && !valid_q[alu_idx];

  ioreseq_slot_mem #(
    .DEPTH (WINDOW),
    .WIDTH (SW),
    .AW    (IW)
  ) u_slot_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (alu_idx),
    .wdata_i (pay_q),
    .raddr_i (alu_idx),
    .rdata_o (mem_rdata)
  );

  always_comb begin
    state_d      = state_q;
    exp_d        = exp_q;
    head_d       = head_q;
    valid_d      = valid_q;
    seq_d        = seq_q;
    pay_d        = pay_q;
    out_valid_d  = out_valid_q && !m_axis_tready_i;
    out_status_d = out_status_q;
    out_seq_d    = out_seq_q;
    out_pay_d    = out_pay_q;
    out_last_d   = out_last_q;

    case (state_q)
      S_IDLE: begin
        if (cfg_req) begin
          // The buffered items no longer relate to the new base.
          exp_d   = cfg_data_i;
          valid_d = '0;
        end else if (in_req) begin
          seq_d   = s_axis_tdata_i[SEQ_W-1:0];
          pay_d   = s_axis_tdata_i[SEQ_W +: SW];
          state_d = S_EVAL;
        end
      end
      S_EVAL: begin
        if (alu_diff == '0) begin
          // In-order item: it is delivered from ADV once its last flag is known.
          state_d = S_ADV;
        end else if (out_free) begin
          out_valid_d = 1'b1;
          out_seq_d   = seq_q;
          out_pay_d   = '0;
          out_last_d  = 1'b1;
          state_d     = S_IDLE;
          if (!alu_in_win) begin
            out_status_d = ST_DROP;
          end else if (valid_q[alu_idx]) begin
            out_status_d = ST_DUP;
          end else begin
            out_status_d     = ST_STORED;
            valid_d[alu_idx] = 1'b1;
          end
        end
      end
      S_ADV: begin
        if (out_free) begin
          // Deliver the item at the head; the run goes on while the next slot is full.
          out_valid_d  = 1'b1;
          out_status_d = ST_DELIVER;
          out_seq_d    = exp_q;
          out_pay_d    = pay_q;
          out_last_d   = !valid_q[alu_idx];
          exp_d        = alu_diff;
          head_d       = alu_idx;
          if (valid_q[alu_idx]) begin
            valid_d[alu_idx] = 1'b0;
            state_d          = S_RD;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      S_RD: begin
        pay_d   = mem_rdata;
        state_d = S_ADV;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      exp_q       <= '0;
      head_q      <= '0;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      exp_q       <= exp_d;
      head_q      <= head_d;
      valid_q     <= valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    seq_q        <= seq_d;
    pay_q        <= pay_d;
    out_status_q <= out_status_d;
    out_seq_q    <= out_seq_d;
    out_pay_q    <= out_pay_d;
    out_last_q   <= out_last_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {PAY_W'(out_pay_q), out_seq_q};
  assign m_axis_tuser_o  = out_status_q;
  assign m_axis_tlast_o  = out_last_q;

`ifndef SYNTHESIS
  // The head slot stands for the expected number and is never occupied.
  a_head_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE |-> !valid_q[head_q])
    else $error("head slot occupied while idle");

  // Only a delivery run produces results that are not the last of a request.
  a_mid_run_delivers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tlast_o |-> m_axis_tuser_o == ST_DELIVER)
    else $error("non-final result with a status other than delivered");

  // A payload read is only issued by a delivery step.
  a_rd_after_adv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_RD |-> $past(state_q) == S_ADV)
    else $error("payload read without a delivery step");

  // An accepted request is classified in the following cycle.
  a_accept_eval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> state_q == S_EVAL)
    else $error("accepted request not evaluated");
`endif

endmodule

// ===== rtl/core/ioreseq_alu.sv =====
// Shared sequence arithmetic unit: one 16-bit adder and one slot index adder.
// Depends on ioreseq_pkg.
module ioreseq_alu #(
  parameter int unsigned WINDOW = 64,
  parameter int unsigned IW     = 6
) (
  input  ioreseq_pkg::alu_op_e op_i,
  input  ioreseq_pkg::seq_t    a_i,
  input  ioreseq_pkg::seq_t    b_i,
  input  logic [IW-1:0]        base_i,
  output ioreseq_pkg::seq_t    diff_o,
  output logic                 in_win_o,
  output logic [IW-1:0]        idx_o
);
  import ioreseq_pkg::*;

  seq_t          addend;
  seq_t          diff;
  logic [IW-1:0] off;
  logic [IW:0]   sum;

  // Distance mode gives a - b, increment mode gives a + 1.
  assign addend   = (op_i == ALU_DIST) ? ~b_i : '0;
  assign diff     = a_i + addend + seq_t'(1);
  assign diff_o   = diff;
  assign in_win_o = (diff < seq_t'(WINDOW));

  // Physical slot index: base plus offset, wrapped into the window.
  assign off   = (op_i == ALU_DIST) ? diff[IW-1:0] : IW'(1);
  assign sum   = {1'b0, base_i} + {1'b0, off};
  assign idx_o = (sum >= (IW+1)'(WINDOW)) ? IW'(sum - (IW+1)'(WINDOW)) : sum[IW-1:0];

endmodule

// ===== rtl/core/ioreseq_slot_mem.sv =====
// Payload store for buffered items: one write port, one registered read port.
// No dependencies.
module ioreseq_slot_mem #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 32,
  parameter int unsigned AW    = 6
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the in-order resequencer.
// Depends on ioreseq_pkg and in_order_resequencer; predicts every result and checks it.
module tb;
  import ioreseq_pkg::*;

  localparam int unsigned WIN       = 64;
  localparam int unsigned LIMIT     = 400000;
  localparam int unsigned STALL_AT  = 80;
  localparam int unsigned STALL_LEN = 500;
  localparam int unsigned SETTLE    = 12;

  // One request on the input stream: a sequence number and its payload token.
  typedef struct packed {
    logic [PAY_W-1:0] pay;
    seq_t             seq;
  } notif_t;

  // One result the block must release, in the order it must release it.
  typedef struct {
    status_e          st;
    seq_t             seq;
    logic [PAY_W-1:0] pay;
    logic             last;
  } release_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  seq_t               cfg_data = '0;
  logic               s_valid = 1'b0;
  logic               s_ready;
  logic [TDATA_W-1:0] s_data = '0;
  logic               m_valid;
  logic               m_ready = 1'b0;
  logic [TDATA_W-1:0] m_data;
  logic [STATUS_W-1:0] m_user;
  logic               m_last;

  in_order_resequencer #(
    .WINDOW      (WIN),
    .PAYLOAD_BITS(PAY_W)
  ) DUT (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_data_i     (cfg_data),
    .s_axis_tvalid_i(s_valid),
    .s_axis_tready_o(s_ready),
    .s_axis_tdata_i (s_data),
    .m_axis_tvalid_o(m_valid),
    .m_axis_tready_i(m_ready),
    .m_axis_tdata_o (m_data),
    .m_axis_tuser_o (m_user),
    .m_axis_tlast_o (m_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Requests waiting to be offered, and results the block still owes us.
  notif_t   notif_q[$];
  release_t release_q[$];

  int unsigned queued_cnt   = 0;
  int unsigned accepted_cnt = 0;
  int unsigned mismatch_cnt = 0;
  int unsigned cycle_cnt    = 0;
  int unsigned stall_left   = 0;
  bit          stall_done   = 1'b0;
  int unsigned tx_idle_pct  = 0;
  int unsigned rx_idle_pct  = 0;

  // Shadow of the reorder buffer. Slot k stands for sequence number
  // next_seq + k, exactly as the hardware window is defined.
  seq_t             next_seq = '0;
  bit               slot_full [WIN];
  logic [PAY_W-1:0] slot_pay  [WIN];

  // Sequence number the stimulus generator believes the block expects next.
  seq_t gen_base = '0;

  // Deliver the head of the window: the base moves up by one and every
  // slot slides down one position.
  function automatic void slide_window();
    for (int i = 0; i + 1 < WIN; i++) begin
      slot_full[i] = slot_full[i+1];
      slot_pay[i]  = slot_pay[i+1];
    end
    slot_full[WIN-1] = 1'b0;
    slot_pay[WIN-1]  = '0;
    next_seq = next_seq + 1'b1;
  endfunction

  // Work out every result one accepted request causes and queue them.
  function automatic void predict_release(notif_t n);
    seq_t     gap;
    release_t run[$];
    gap = n.seq - next_seq;
    if (gap == 0) begin
      // In-order arrival: deliver it, then drain the run of filled slots
      // behind it. The window bounds the run length.
      run.push_back('{ST_DELIVER, n.seq, n.pay, 1'b0});
      slide_window();
      while (run.size() < WIN && slot_full[0]) begin
        run.push_back('{ST_DELIVER, next_seq, slot_pay[0], 1'b0});
        slide_window();
      end
      run[run.size()-1].last = 1'b1;
      foreach (run[i]) release_q.push_back(run[i]);
    end else if (gap < WIN) begin
      // Ahead but inside the window: store it unless the slot is taken,
      // in which case the first payload wins.
      if (slot_full[gap]) begin
        release_q.push_back('{ST_DUP, n.seq, '0, 1'b1});
      end else begin
        slot_full[gap] = 1'b1;
        slot_pay[gap]  = n.pay;
        release_q.push_back('{ST_STORED, n.seq, '0, 1'b1});
      end
    end else begin
      // Behind the expected number or beyond the window.
      release_q.push_back('{ST_DROP, n.seq, '0, 1'b1});
    end
  endfunction

  // Input driver. valid is held until the request is taken; a new request
  // goes out only in a cycle the sender does not choose to idle.
  always @(posedge clk or negedge rst_n) begin
    notif_t cur;
    if (!rst_n) begin
      s_valid <= 1'b0;
    end else begin
      if (s_valid && s_ready) begin
        cur = s_data;
        predict_release(cur);
        accepted_cnt++;
      end
      if (!s_valid || s_ready) begin
        if (notif_q.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
          cur = notif_q.pop_front();
          s_data  <= cur;
          s_valid <= 1'b1;
        end else begin
          s_valid <= 1'b0;
        end
      end
    end
  end

  // A single long back-pressure episode on the output. It starts once enough
  // requests have gone in, while the sender still has plenty to offer, so the
  // block fills up and has to stall its input.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      stall_left <= 0;
      stall_done <= 1'b0;
    end else if (!stall_done && accepted_cnt >= STALL_AT) begin
      stall_left <= STALL_LEN;
      stall_done <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end
  end

  // Output monitor: every released result is checked against the oldest
  // outstanding prediction, field by field.
  always @(posedge clk or negedge rst_n) begin
    release_t want;
    seq_t     got_seq;
    logic [PAY_W-1:0] got_pay;
    if (!rst_n) begin
      m_ready <= 1'b0;
    end else begin
      if (m_valid && m_ready) begin
        got_seq = m_data[SEQ_W-1:0];
        got_pay = m_data[TDATA_W-1:SEQ_W];
        if (release_q.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("unexpected result: status=%0d seq=%h payload=%h last=%b",
                     m_user, got_seq, got_pay, m_last);
        end else begin
          want = release_q.pop_front();
          if (m_user !== want.st || got_seq !== want.seq || got_pay !== want.pay ||
              m_last !== want.last) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
              $display("mismatch: expected status=%0d seq=%h payload=%h last=%b, got status=%0d seq=%h payload=%h last=%b",
                       want.st, want.seq, want.pay, want.last,
                       m_user, got_seq, got_pay, m_last);
          end
        end
      end
      m_ready <= (stall_left == 0) && ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic push_notif(seq_t seq, logic [PAY_W-1:0] pay);
    notif_q.push_back('{pay, seq});
    queued_cnt++;
  endtask

  // Let every queued request go in and every predicted result come out,
  // then let the block settle.
  task automatic wait_idle();
    while (accepted_cnt != queued_cnt || release_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Program the start sequence number. The block is idle here, so the
  // shadow buffer is reset the same way: counter loaded, all slots emptied.
  task automatic write_start(seq_t value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    next_seq = value;
    gen_base = value;
    foreach (slot_full[i]) slot_full[i] = 1'b0;
  endtask

  // A well-formed run: the numbers gen_base .. gen_base+len-1 in shuffled
  // order, with the odd repeat thrown in. When head_last is set the in-order
  // number arrives last, so the whole run drains in one go.
  task automatic queue_burst(int unsigned len, bit head_last);
    seq_t        order[$];
    seq_t        tmp;
    int unsigned j;
    for (int unsigned i = 0; i < len; i++) order.push_back(gen_base + seq_t'(i));
    for (int unsigned i = len - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    if (head_last) begin
      foreach (order[i]) begin
        if (order[i] == gen_base) begin
          order[i] = order[len-1];
          order[len-1] = gen_base;
        end
      end
    end
    foreach (order[i]) begin
      push_notif(order[i], $urandom);
      if ($urandom_range(0, 99) < 8) push_notif(order[$urandom_range(0, i)], $urandom);
    end
    gen_base = gen_base + seq_t'(len);
  endtask

  // Noise: stale numbers, numbers far ahead of the window, or anything at all.
  task automatic queue_noise();
    case ($urandom_range(0, 2))
      0: push_notif(gen_base - seq_t'($urandom_range(1, 3000)), $urandom);
      1: push_notif(gen_base + seq_t'($urandom_range(WIN, 32000)), $urandom);
      default: push_notif(seq_t'($urandom_range(0, 65535)), $urandom);
    endcase
  endtask

  // Random traffic until the request count reaches target. Each stretch opens
  // with a full-window run so the longest drain shows up every time.
  task automatic queue_random(int unsigned target);
    int unsigned pick;
    queue_burst(WIN, 1'b1);
    while (queued_cnt < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 20) begin
        queue_noise();
      end else if (pick < 75) begin
        queue_burst($urandom_range(1, 8), $urandom_range(0, 3) == 0);
      end else if (pick < 97) begin
        queue_burst($urandom_range(9, 32), $urandom_range(0, 3) == 0);
      end else begin
        queue_burst(WIN, $urandom_range(0, 1));
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    tx_idle_pct = 34;
    rx_idle_pct = 45;

    // Directed part, starting just below the wrap point so the window
    // straddles it.
    write_start(16'hFFFE);
    push_notif(16'h0001, 32'hFFFF_FFFF);  // ahead by three: stored
    push_notif(16'h0001, 32'h0000_0000);  // same slot again: duplicate
    push_notif(16'hFFFF, 32'h1234_5678);  // ahead by one: stored
    push_notif(16'h003D, 32'h0000_0000);  // last slot of the window: stored
    push_notif(16'h003E, 32'hFFFF_FFFF);  // one past the window: dropped
    push_notif(16'hFFFD, 32'h0000_0000);  // one behind: stale, dropped
    push_notif(16'hFFFE, 32'hA5A5_A5A5);  // in order: releases FFFE and FFFF
    push_notif(16'hFFFF, 32'h0000_0001);  // already delivered: stale
    push_notif(16'h0000, 32'h0000_0000);  // in order across the wrap: 0 and 1
    push_notif(16'h0002, 32'hFFFF_FFFF);  // in order, nothing behind it
    push_notif(16'h8003, 32'h5A5A_5A5A);  // half the number space away
    push_notif(16'h0004, 32'h0F0F_0F0F);  // ahead by one: stored
    push_notif(16'h0003, 32'hF0F0_F0F0);  // in order: releases 3 and 4
    push_notif(16'h003D, 32'h0000_0000);  // still held from before: duplicate
    wait_idle();

    // Random traffic, sender idling less than the receiver.
    write_start(16'h0000);
    queue_random(180);
    wait_idle();

    // Receiver idling less than the sender. Midway the sender pauses until
    // every outstanding result has come back.
    tx_idle_pct = 45;
    rx_idle_pct = 34;
    write_start(16'hFFFF);
    queue_random(260);
    wait_idle();
    queue_random(340);
    wait_idle();

    // No idling on either side.
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    write_start(seq_t'($urandom_range(0, 65535)));
    queue_random(460);
    wait_idle();

    repeat (20) @(posedge clk);
    if (mismatch_cnt == 0 && release_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
